[rtl/core/cobs_frame_decoder_macros.svh]
// ----------------------------------------------------------------------------
// COBS frame decoder assertion macros
// Shared property shorthands for the decoder's internal checks.
// ----------------------------------------------------------------------------
`ifndef COBS_FRAME_DECODER_MACROS_SVH
`define COBS_FRAME_DECODER_MACROS_SVH

// same-cycle implication, disabled while reset is low
`define CFD_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("cobs frame decoder check failed");

// next-cycle implication, disabled while reset is low
`define CFD_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("cobs frame decoder check failed");

`endif

[rtl/core/cobsfd_pkg.sv]
// ----------------------------------------------------------------------------
// COBS frame decoder package
// Shared constants, status codes and the queue entry type.
// ----------------------------------------------------------------------------
package cobsfd_pkg;

    localparam int QUEUE_DEPTH = 4;
    localparam int CAP_W       = 16;

    localparam logic [15:0] CAPACITY_RESET = 16'hFFFF;
    localparam logic [7:0]  CODE_MAX       = 8'hFF;
    localparam logic [7:0]  BYTE_ZERO      = 8'h00;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_INVALID   = 2'd1;
    localparam logic [1:0] ST_TOO_SMALL = 2'd2;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // results caused by one input transfer
    typedef struct packed {
        logic        has_data;
        logic [7:0]  data_byte;
        logic        has_status;
        logic [1:0]  status;
        logic [15:0] count;
    } entry_t;

endpackage

[rtl/core/cobs_frame_decoder.sv]
// ----------------------------------------------------------------------------
// COBS frame decoder
// Decodes byte-stuffed frames (terminator removed) into data bytes plus one
// end-of-frame status result per frame.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream: one stuffed byte per transfer on s_tdata, s_tlast on the
//   final byte of a frame. Output stream: decoded bytes (m_tuser = 0) and a
//   status result (m_tuser = 1) carrying the frame status and decoded count;
//   m_tlast marks the last result caused by one input byte.
//   cfg_wr_en / cfg_wr_data set the output capacity; write only while idle.
//   A result is registered in the entry queue and then in the output
//   register before it is presented.
//   Throughput: one input byte per cycle while the queue is not full. An
//   input that causes two results (inserted zero plus status, or data plus
//   status) is presented from the output registers as two results in turn;
//   the entry queue between the front and back ends absorbs the difference.
//   When the receiver stalls, results wait in the output register and the
//   queue; s_tready drops once the queue is full.
//   Reset clears frame state, empties the queue and sets capacity to 65535.
// ----------------------------------------------------------------------------
module cobs_frame_decoder #(
    parameter int QUEUE_DEPTH = cobsfd_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,    // [7:0] in_byte
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,    // [7:0] out_byte, [9:8] frame_status,
                                    // [25:10] decoded_count, [31:26] zero
    output logic        m_tuser,    // [0] out_kind
    output logic        m_tlast
);

    logic               q_push;
    logic               q_full;
    logic               q_pop;
    logic               q_head_valid;
    cobsfd_pkg::entry_t q_entry;
    cobsfd_pkg::entry_t q_head;

    logic [7:0]         m_byte;
    logic [1:0]         m_status;
    logic [15:0]        m_count;

    cobsfd_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_entry     (q_entry)
    );

    cobsfd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (q_entry),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (q_head_valid),
        .head_entry (q_head)
    );

    cobsfd_back u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head_valid (q_head_valid),
        .head_entry (q_head),
        .pop        (q_pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_kind     (m_tuser),
        .m_byte     (m_byte),
        .m_status   (m_status),
        .m_count    (m_count),
        .m_last     (m_tlast)
    );

    assign m_tdata = {6'd0, m_count, m_status, m_byte};

endmodule

[rtl/core/cobsfd_front.sv]
// ----------------------------------------------------------------------------
// COBS frame decoder front end
// Accepts stuffed bytes, tracks block and frame state, and queues the
// results each byte causes.
// ----------------------------------------------------------------------------
module cobsfd_front (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_wr_en,
    input  logic [15:0]           cfg_wr_data,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,
    input  logic                  s_tlast,
    input  logic                  q_full,
    output logic                  q_push,
    output cobsfd_pkg::entry_t    q_entry
);

    logic [15:0] capacity_reg, capacity_next;
    logic [7:0]  left_reg, left_next;
    logic        zero_pend_reg, zero_pend_next;
    logic [15:0] count_reg, count_next;
    logic        discard_reg, discard_next;

    logic        accept;
    logic        room;
    logic        done;
    logic        has_data;
    logic [7:0]  data_byte;
    logic [1:0]  status;

    assign s_tready = !q_full;
    assign accept   = s_tvalid && s_tready;
    assign room     = count_reg < capacity_reg;

    always_comb begin
        capacity_next = cfg_wr_en ? cfg_wr_data : capacity_reg;
    end

    always_comb begin
        left_next      = left_reg;
        zero_pend_next = zero_pend_reg;
        count_next     = count_reg;
        discard_next   = discard_reg;
        done           = 1'b0;
        has_data       = 1'b0;
        data_byte      = s_tdata;
        status         = cobsfd_pkg::ST_OK;
        if (accept) begin
            if (discard_reg) begin
                if (s_tlast) begin
                    discard_next = 1'b0;
                end
            end else begin
                if (left_reg == 8'd0) begin
                    if (s_tdata == cobsfd_pkg::BYTE_ZERO) begin
                        status = cobsfd_pkg::ST_INVALID;
                        done   = 1'b1;
                    end else begin
                        if (zero_pend_reg) begin
                            if (!room) begin
                                status = cobsfd_pkg::ST_TOO_SMALL;
                                done   = 1'b1;
                            end else begin
                                has_data   = 1'b1;
                                data_byte  = cobsfd_pkg::BYTE_ZERO;
                                count_next = count_reg + 16'd1;
                            end
                        end
                        if (!done) begin
                            left_next      = s_tdata - 8'd1;
                            zero_pend_next = s_tdata != cobsfd_pkg::CODE_MAX;
                        end
                    end
                end else begin
                    if (!room) begin
                        status = cobsfd_pkg::ST_TOO_SMALL;
                        done   = 1'b1;
                    end else begin
                        has_data   = 1'b1;
                        count_next = count_reg + 16'd1;
                        left_next  = left_reg - 8'd1;
                    end
                end
                if (!done && s_tlast) begin
                    status = (left_next != 8'd0) ? cobsfd_pkg::ST_INVALID
                                                 : cobsfd_pkg::ST_OK;
                    done   = 1'b1;
                end
                if (done) begin
                    left_next      = 8'd0;
                    zero_pend_next = 1'b0;
                    count_next     = 16'd0;
                    discard_next   = !s_tlast;
                end
            end
        end
    end

    always_comb begin
        q_push             = accept && (has_data || done);
        q_entry.has_data   = has_data;
        q_entry.data_byte  = data_byte;
        q_entry.has_status = done;
        q_entry.status     = status;
        q_entry.count      = has_data ? count_reg + 16'd1 : count_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            capacity_reg  <= cobsfd_pkg::CAPACITY_RESET;
            left_reg      <= 8'd0;
            zero_pend_reg <= 1'b0;
            count_reg     <= 16'd0;
            discard_reg   <= 1'b0;
        end else begin
            capacity_reg  <= capacity_next;
            left_reg      <= left_next;
            zero_pend_reg <= zero_pend_next;
            count_reg     <= count_next;
            discard_reg   <= discard_next;
        end
    end

endmodule

[rtl/core/cobsfd_queue.sv]
// ----------------------------------------------------------------------------
// COBS frame decoder queue
// Short FIFO of result entries between the front and back ends.
// ----------------------------------------------------------------------------
`include "cobs_frame_decoder_macros.svh"

module cobsfd_queue #(
    parameter int DEPTH = cobsfd_pkg::QUEUE_DEPTH
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  push,
    input  cobsfd_pkg::entry_t    push_entry,
    output logic                  full,
    input  logic                  pop,
    output logic                  head_valid,
    output cobsfd_pkg::entry_t    head_entry
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    cobsfd_pkg::entry_t mem [DEPTH];

    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full       = count_reg == CNT_W'(DEPTH);
    assign head_valid = count_reg != '0;
    assign head_entry = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (pop && !push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    `CFD_ASSERT_IMP(a_no_push_full, aclk, aresetn, push, !full)
    `CFD_ASSERT_IMP(a_no_pop_empty, aclk, aresetn, pop, head_valid)
    `CFD_ASSERT_NXT(a_push_fills, aclk, aresetn, push && !pop, head_valid)
    `CFD_ASSERT_IMP(a_entry_nonempty, aclk, aresetn, head_valid,
                    head_entry.has_data || head_entry.has_status)

endmodule

[rtl/core/cobsfd_back.sv]
// ----------------------------------------------------------------------------
// COBS frame decoder back end
// Unpacks queued entries into data and status results on a registered
// output stage.
// ----------------------------------------------------------------------------
module cobsfd_back (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  head_valid,
    input  cobsfd_pkg::entry_t    head_entry,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic                  m_kind,
    output logic [7:0]            m_byte,
    output logic [1:0]            m_status,
    output logic [15:0]           m_count,
    output logic                  m_last
);

    logic        valid_reg, valid_next;
    logic        phase_reg, phase_next;
    logic        kind_reg, kind_next;
    logic [7:0]  byte_reg, byte_next;
    logic [1:0]  status_reg, status_next;
    logic [15:0] count_reg, count_next;
    logic        last_reg, last_next;

    logic        load;
    logic        emit_data;

    assign load      = head_valid && (!valid_reg || m_tready);
    assign emit_data = head_entry.has_data && !phase_reg;

    always_comb begin
        valid_next  = valid_reg;
        phase_next  = phase_reg;
        kind_next   = kind_reg;
        byte_next   = byte_reg;
        status_next = status_reg;
        count_next  = count_reg;
        last_next   = last_reg;
        pop         = 1'b0;
        if (valid_reg && m_tready) begin
            valid_next = 1'b0;
        end
        if (load) begin
            valid_next = 1'b1;
            if (emit_data) begin
                kind_next   = cobsfd_pkg::KIND_DATA;
                byte_next   = head_entry.data_byte;
                status_next = cobsfd_pkg::ST_OK;
                count_next  = 16'd0;
                last_next   = !head_entry.has_status;
            end else begin
                kind_next   = cobsfd_pkg::KIND_STATUS;
                byte_next   = cobsfd_pkg::BYTE_ZERO;
                status_next = head_entry.status;
                count_next  = head_entry.count;
                last_next   = 1'b1;
            end
            if (emit_data && head_entry.has_status) begin
                phase_next = 1'b1;
            end else begin
                phase_next = 1'b0;
                pop        = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
            phase_reg <= phase_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg   <= kind_next;
        byte_reg   <= byte_next;
        status_reg <= status_next;
        count_reg  <= count_next;
        last_reg   <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_kind   = kind_reg;
    assign m_byte   = byte_reg;
    assign m_status = status_reg;
    assign m_count  = count_reg;
    assign m_last   = last_reg;

endmodule

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// COBS frame decoder testbench
// Feeds directed and random stuffed frames (well-formed, truncated, corrupted
// and noise) through the decoder under several output capacities and idle
// patterns, predicts every data and status transfer and checks each one.
// ----------------------------------------------------------------------------
module tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int PHASE_ITEMS  = 80;
    localparam int REPORT_LIMIT = 10;

    typedef logic [7:0] byte_q_t[$];

    typedef struct packed {
        logic        kind;
        logic [7:0]  data;
        logic [1:0]  status;
        logic [15:0] count;
        logic        last;
    } result_t;

    class decode_scoreboard;
        logic [15:0] capacity;
        logic [7:0]  bytes_left;
        logic        zero_pending;
        logic [15:0] written;
        logic        discarding;
        result_t     expected_results[$];
        int          mismatches;

        function new();
            capacity     = cobsfd_pkg::CAPACITY_RESET;
            bytes_left   = '0;
            zero_pending = 1'b0;
            written      = '0;
            discarding   = 1'b0;
            mismatches   = 0;
        endfunction

        function void absorb_byte(logic [7:0] b, logic last);
            result_t    outs[2];
            int         n;
            logic [1:0] st;
            logic       done;
            n    = 0;
            st   = cobsfd_pkg::ST_OK;
            done = 1'b0;
            if (discarding) begin
                if (last) begin
                    discarding = 1'b0;
                end
                return;
            end
            if (bytes_left == 0) begin
                if (b == cobsfd_pkg::BYTE_ZERO) begin
                    st   = cobsfd_pkg::ST_INVALID;
                    done = 1'b1;
                end else begin
                    if (zero_pending) begin
                        if (written >= capacity) begin
                            st   = cobsfd_pkg::ST_TOO_SMALL;
                            done = 1'b1;
                        end else begin
                            outs[n] = {cobsfd_pkg::KIND_DATA, cobsfd_pkg::BYTE_ZERO,
                                       cobsfd_pkg::ST_OK, 16'd0, 1'b0};
                            n++;
                            written++;
                        end
                    end
                    if (!done) begin
                        bytes_left   = b - 8'd1;
                        zero_pending = (b != cobsfd_pkg::CODE_MAX);
                    end
                end
            end else begin
                if (written >= capacity) begin
                    st   = cobsfd_pkg::ST_TOO_SMALL;
                    done = 1'b1;
                end else begin
                    outs[n] = {cobsfd_pkg::KIND_DATA, b, cobsfd_pkg::ST_OK, 16'd0, 1'b0};
                    n++;
                    written++;
                    bytes_left--;
                end
            end
            if (!done && last) begin
                st   = (bytes_left != 0) ? cobsfd_pkg::ST_INVALID : cobsfd_pkg::ST_OK;
                done = 1'b1;
            end
            if (done) begin
                outs[n] = {cobsfd_pkg::KIND_STATUS, cobsfd_pkg::BYTE_ZERO, st, written, 1'b0};
                n++;
                bytes_left   = '0;
                zero_pending = 1'b0;
                written      = '0;
                discarding   = !last;
            end
            if (n > 0) begin
                outs[n-1].last = 1'b1;
            end
            for (int i = 0; i < n; i++) begin
                expected_results.push_back(outs[i]);
            end
        endfunction

        function void report(string what, result_t want, result_t got);
            mismatches++;
            if (mismatches <= REPORT_LIMIT) begin
                $display("%0t: %s: expected kind %0d byte %02h status %0d count %0d last %0d",
                         $time, what, want.kind, want.data, want.status, want.count, want.last);
                $display("%0t: %s: actual   kind %0d byte %02h status %0d count %0d last %0d",
                         $time, what, got.kind, got.data, got.status, got.count, got.last);
            end
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (expected_results.size() == 0) begin
                report("unexpected transfer", '0, got);
                return;
            end
            want = expected_results.pop_front();
            if (got != want) begin
                report("mismatch", want, got);
            end
        endfunction
    endclass

    logic        aclk        = 1'b0;
    logic        aresetn     = 1'b0;
    logic        cfg_wr_en   = 1'b0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;
    logic        s_tlast     = 1'b0;
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [31:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    decode_scoreboard sb = new();

    int unsigned send_idle_pct = 0;
    int unsigned recv_stall_pct = 0;
    logic        hold_req = 1'b0;
    int          hold_left = 0;
    int          items_sent = 0;
    int          cycle_count = 0;

    cobs_frame_decoder u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    // receiver: random stalls, or a long hold-off on request
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = HOLD_CYCLES;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_tready <= 1'b0;
            hold_left--;
        end else begin
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            sb.check_result({m_tuser, m_tdata[7:0], m_tdata[9:8], m_tdata[25:10], m_tlast});
        end
    end

    // called at a falling edge, returns at the falling edge after the transfer
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
        sb.absorb_byte(b, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_stuffed(input byte_q_t coded);
        foreach (coded[i]) begin
            send_byte(coded[i], i == coded.size() - 1);
        end
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        while (sb.expected_results.size() != 0) begin
            @(negedge aclk);
        end
        repeat (DRAIN_CYCLES) @(negedge aclk);
    endtask

    task automatic write_capacity(input logic [15:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(negedge aclk);
        cfg_wr_en   <= 1'b0;
        sb.capacity = value;
    endtask

    function automatic byte_q_t stuff_frame(input byte_q_t raw);
        byte_q_t    coded;
        int         code_pos;
        logic [7:0] code;
        coded.push_back(cobsfd_pkg::BYTE_ZERO);
        code_pos = 0;
        code     = 8'd1;
        foreach (raw[i]) begin
            if (raw[i] == cobsfd_pkg::BYTE_ZERO) begin
                coded[code_pos] = code;
                coded.push_back(cobsfd_pkg::BYTE_ZERO);
                code_pos = coded.size() - 1;
                code     = 8'd1;
            end else begin
                coded.push_back(raw[i]);
                code++;
                if (code == cobsfd_pkg::CODE_MAX) begin
                    coded[code_pos] = code;
                    coded.push_back(cobsfd_pkg::BYTE_ZERO);
                    code_pos = coded.size() - 1;
                    code     = 8'd1;
                end
            end
        end
        coded[code_pos] = code;
        return coded;
    endfunction

    task automatic send_random_frame();
        byte_q_t raw;
        byte_q_t coded;
        int      pick;
        int      len;
        int      zero_pct;
        int      cut;
        pick = $urandom_range(99);
        if (pick < 10) begin
            len = $urandom_range(1, 6);
            repeat (len) coded.push_back(8'($urandom));
        end else begin
            if (pick < 13) begin
                len      = $urandom_range(250, 300);
                zero_pct = 1;
            end else if (pick < 25) begin
                len      = $urandom_range(13, 40);
                zero_pct = 20;
            end else begin
                len      = $urandom_range(0, 12);
                zero_pct = 25;
            end
            repeat (len) begin
                if ($urandom_range(99) < zero_pct) begin
                    raw.push_back(cobsfd_pkg::BYTE_ZERO);
                end else begin
                    raw.push_back(8'($urandom_range(1, 255)));
                end
            end
            coded = stuff_frame(raw);
            if (pick >= 80 && pick < 90) begin
                cut   = $urandom_range(1, coded.size());
                coded = coded[0:cut-1];
            end else if (pick >= 90) begin
                cut = $urandom_range(0, coded.size() - 1);
                coded[cut] = $urandom_range(1) ? cobsfd_pkg::BYTE_ZERO : 8'($urandom);
            end
        end
        send_stuffed(coded);
    endtask

    initial begin
        logic [15:0] cap;
        int          phase_end;
        logic        paused;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // default capacity
        send_stuffed('{8'h01});
        send_stuffed('{8'h02, 8'hFF});
        send_stuffed('{8'h03, 8'h00, 8'h80});
        send_stuffed('{8'h01, 8'h01});
        send_stuffed('{8'h00});
        send_stuffed('{8'h02, 8'h05, 8'h00});
        send_stuffed('{8'h03, 8'h07});
        send_stuffed('{8'h02, 8'h09, 8'h04});
        send_stuffed('{8'hFF});
        send_stuffed('{8'h00, 8'h55, 8'h12});
        wait_drained();

        // no room at all
        write_capacity(16'd0);
        send_stuffed('{8'h02, 8'h33});
        send_stuffed('{8'h01, 8'h01});
        wait_drained();

        // room for one byte
        write_capacity(16'd1);
        send_stuffed('{8'h03, 8'h0A, 8'h0B});
        wait_drained();

        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  cap = 16'hFFFF;
                end
                1: begin
                    send_idle_pct = 68; recv_stall_pct = 0;  cap = 16'd9;
                end
                2: begin
                    send_idle_pct = 0;  recv_stall_pct = 68; cap = 16'd30;
                end
                3: begin
                    send_idle_pct = 28; recv_stall_pct = 28; cap = 16'd2;
                end
                default: begin
                    send_idle_pct = 0;  recv_stall_pct = 0;  cap = 16'($urandom);
                end
            endcase
            write_capacity(cap);
            phase_end = items_sent + PHASE_ITEMS;
            paused    = 1'b0;
            while (items_sent < phase_end) begin
                if (phase == 0 && !paused && items_sent + PHASE_ITEMS - 20 >= phase_end) begin
                    hold_req = 1'b1;
                    paused   = 1'b1;
                end
                if (phase == 1 && !paused && items_sent + PHASE_ITEMS / 2 >= phase_end) begin
                    wait_drained();
                    paused = 1'b1;
                end
                send_random_frame();
            end
            wait_drained();
        end

        if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end
endmodule

[cobs_frame_decoder.f]
+incdir+rtl/core
rtl/core/cobsfd_pkg.sv
rtl/core/cobsfd_front.sv
rtl/core/cobsfd_queue.sv
rtl/core/cobsfd_back.sv
rtl/core/cobs_frame_decoder.sv
tb/tb.sv
